[rtl/sal_pkg.sv]
// Shared types, constants and request codes for the sorted array list.
package sal_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = 32;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]           req_type;
        logic signed [KW-1:0] key;
        logic [5:0]           index;
    } sal_req_t;

    typedef struct packed {
        logic                 ok;
        logic [6:0]           count;
        logic signed [KW-1:0] read_key;
    } sal_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_DEL_CMP,
        ST_DEL_SHIFT,
        ST_RD_WAIT,
        ST_RESP
    } sal_state_t;

endpackage

[rtl/sorted_array_list.sv]
// Top level of the sorted array list: key store, request sequencer and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------
//  request | req_valid | req_stall | req  (req_type, key, index)
//  result  | rsp_valid | rsp_stall | rsp  (ok, count, read_key)
//
// One request at a time; req_stall is high from acceptance until the result
// is loaded into the output register. Clear, append, an insert into an empty
// list and the full-list and empty-list failures go straight to the result;
// a read waits for the registered key memory; a sorted insert shifts up every
// key greater than the new one; a delete searches for a match and shifts down.
// The key memory has a single write port, so a shift moves one entry per cycle.
// Reset (rst_n low, async) empties the list; stored keys are not cleared.
// A stalled result holds the sequencer in the result state until taken.
module sorted_array_list (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sal_pkg::sal_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sal_pkg::sal_rsp_t rsp
);
    import sal_pkg::*;

    // key store: one write port, one registered read port
    logic [KW-1:0] mem [DEPTH];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_data_reg;

    sal_state_t    state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [KW-1:0] key_reg, key_next;
    logic          res_ok_reg, res_ok_next;
    logic [KW-1:0] res_key_reg, res_key_next;
    logic          rsp_valid_reg, rsp_valid_next;
    sal_rsp_t      rsp_reg, rsp_next;

    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] ptr_inc;
    logic          slot_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        key_reg     <= key_next;
        res_ok_reg  <= res_ok_next;
        res_key_reg <= res_key_next;
        rsp_reg     <= rsp_next;
    end

    assign ptr_dec   = ptr_reg - CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        res_ok_next    = res_ok_reg;
        res_key_next   = res_key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = key_reg;
        rd_addr        = ptr_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next     = req.key;
                    res_ok_next  = 1'b0;
                    res_key_next = '0;
                    state_next   = ST_RESP;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (used_reg < CW'(DEPTH))
                            begin
                                if (used_reg == '0)
                                begin
                                    // empty list: key goes straight to slot 0
                                    wr_en       = 1'b1;
                                    wr_addr     = '0;
                                    wr_data     = req.key;
                                    used_next   = CW'(1);
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    ptr_next   = used_reg;
                                    rd_addr    = AW'(used_reg - CW'(1));
                                    state_next = ST_INS_CMP;
                                end
                            end
                        end
                        REQ_APPEND:
                        begin
                            if (used_reg < CW'(DEPTH))
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = used_reg[AW-1:0];
                                wr_data     = req.key;
                                used_next   = used_reg + CW'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (used_reg != '0)
                            begin
                                ptr_next   = '0;
                                rd_addr    = '0;
                                state_next = ST_DEL_CMP;
                            end
                        end
                        REQ_READ:
                        begin
                            if (CW'(req.index) < used_reg)
                            begin
                                rd_addr    = req.index[AW-1:0];
                                state_next = ST_RD_WAIT;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            used_next   = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            // rd_data_reg holds entry ptr-1
            ST_INS_CMP:
            begin
                if ($signed(rd_data_reg) > $signed(key_reg))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[AW-1:0];
                    wr_data  = rd_data_reg;
                    ptr_next = ptr_dec;
                    if (ptr_dec == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr = AW'(ptr_dec - CW'(1));
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = ptr_reg[AW-1:0];
                    wr_data     = key_reg;
                    used_next   = used_reg + CW'(1);
                    res_ok_next = 1'b1;
                    state_next  = ST_RESP;
                end
            end

            ST_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = key_reg;
                used_next   = used_reg + CW'(1);
                res_ok_next = 1'b1;
                state_next  = ST_RESP;
            end

            // rd_data_reg holds entry ptr
            ST_DEL_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_ok_next = 1'b1;
                    if (ptr_inc == used_reg)
                    begin
                        used_next  = used_reg - CW'(1);
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        rd_addr    = ptr_inc[AW-1:0];
                        state_next = ST_DEL_SHIFT;
                    end
                end
                else if (ptr_inc == used_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc[AW-1:0];
                end
            end

            // rd_data_reg holds entry ptr+1, moved down to ptr
            ST_DEL_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_inc;
                if (ptr_inc + CW'(1) == used_reg)
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_addr = AW'(ptr_inc + CW'(1));
                end
            end

            ST_RD_WAIT:
            begin
                res_key_next = rd_data_reg;
                res_ok_next  = 1'b1;
                state_next   = ST_RESP;
            end

            ST_RESP:
            begin
                if (slot_free)
                begin
                    rsp_next.ok       = res_ok_reg;
                    rsp_next.count    = 7'(used_reg);
                    rsp_next.read_key = res_key_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/sal_check.sv]
// Port-level assertions for the sorted array list, bound to the top level.
module sal_check (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input sal_pkg::sal_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input sal_pkg::sal_rsp_t rsp
);
    import sal_pkg::*;

    // a held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one item in flight: accepting an item closes the request side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side open right after an accept");

    // failed results carry a zero key (successful non-read results are not checked)
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.read_key == '0)
        else $error("failed result has nonzero key");

    // count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= 7'(DEPTH))
        else $error("count above capacity");

endmodule

bind sorted_array_list sal_check u_sal_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
